// ===== rtl/sstc_pkg.sv =====
// Shared widths and constants for the sample set time/allocation correlation block.
`timescale 1ns / 1ps
package sstc_pkg;

  // Largest number of samples kept in one set.
  localparam int MAX_SAMPLES = 1024;

  // Field widths.
  localparam int TW  = 40;
  localparam int AKW = 32;
  localparam int UKW = 32;
  localparam int MW  = 48;
  localparam int RW  = 16;
  localparam int EW  = 32;

  // Index and count widths.
  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // Running totals.
  localparam int ATW = AKW + CW;
  localparam int TTW = TW + CW;

  // Scaled samples n*x and their deviations.
  localparam int NXW = TW + CW;
  localparam int NAW = AKW + CW;

  // Second pass accumulators.
  localparam int POSW = NXW + NAW + CW;
  localparam int STTW = 2 * NXW + CW;
  localparam int SAAW = 2 * NAW + CW;
  localparam int RHW  = STTW + SAAW;
  localparam int LHW  = 2 * POSW + 30;

  // Serial multiplier operand and product widths.
  localparam int BW = POSW;
  localparam int PW = ((RHW + 32) > LHW ? (RHW + 32) : LHW) + 1;

  // Shared divider widths.
  localparam int DNW = ATW + 16;
  localparam int DVW = ATW;

endpackage

// ===== rtl/sstc_mul.sv =====
// Shift-and-add multiplier that retires one multiplier bit per cycle.
`timescale 1ns / 1ps
module sstc_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [sstc_pkg::PW-1:0] a_i,
  input  logic [sstc_pkg::BW-1:0] b_i,
  output logic                   done_o,
  output logic [sstc_pkg::PW-1:0] prod_o
);
  import sstc_pkg::*;

  logic          run_q;
  logic [PW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] acc_q;

  // The product is complete once no multiplier bits remain.
  assign done_o = run_q && (b_q == '0);
  assign prod_o = acc_q;

  // Add the shifted multiplicand for each set bit, lowest bit first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      a_q   <= '0;
      b_q   <= '0;
      acc_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (b_q == '0) begin
        run_q <= 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= {a_q[PW-2:0], 1'b0};
        b_q <= {1'b0, b_q[BW-1:1]};
      end
    end
  end

endmodule

// ===== rtl/sstc_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module sstc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [sstc_pkg::DNW-1:0] dividend_i,
  input  logic [sstc_pkg::DVW-1:0] divisor_i,
  output logic                    done_o,
  output logic [sstc_pkg::DNW-1:0] quot_o
);
  import sstc_pkg::*;

  localparam int KW = $clog2(DNW + 1);

  logic           run_q;
  logic [KW-1:0]  cnt_q;
  logic [DNW-1:0] dvd_q;
  logic [DVW-1:0] rem_q;
  logic [DVW-1:0] dvs_q;
  logic [DVW:0]   rem_sh;
  logic           fits;

  assign rem_sh = {rem_q, dvd_q[DNW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign done_o = run_q && (cnt_q == '0);
  assign quot_o = dvd_q;

  // Shift the dividend out at the top and the quotient bits in at the bottom.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      dvd_q <= '0;
      rem_q <= '0;
      dvs_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= KW'(DNW);
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
        // The remainder always stays below the divisor.
        rem_q <= fits ? DVW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVW-1:0];
        dvd_q <= {dvd_q[DNW-2:0], fits};
      end
    end
  end

endmodule

// ===== rtl/sample_set_alloc_time_correlation.sv =====
// Top level: sample set loading, statistics and time/allocation correlation.
`timescale 1ns / 1ps
// Usage: a sample beat is taken at a rising edge with start_i high and busy_o low.
// While a set loads, busy_o stays low and one sample is taken every cycle; each
// sample is written to the sample memory and folded into the running totals.
// Samples past the memory depth are dropped, but their final flag still counts.
// The beat with final_sample_i high closes the set and raises busy_o. The block
// then runs two serial divisions (mean and reciprocal, the second skipped
// when the allocation total is zero), a second pass that reads every stored
// sample back from the memory and runs three bit-serial products per sample,
// then two wide products and a 16-step search for the correlation, each step
// at most one serial product; a flat series skips both and the search.
// The result beat is shown for one cycle with result_valid_o high; the receiver
// must take it then. busy_o drops the cycle after, and the next set may load.
// Reset clears the totals, count and sequencer; the memory holds no reset.
module sample_set_alloc_time_correlation (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [sstc_pkg::TW-1:0]  elapsed_ns_i,
  input  logic [sstc_pkg::AKW-1:0] alloc_kb_i,
  input  logic [sstc_pkg::UKW-1:0] in_use_after_kb_i,
  input  logic                     final_sample_i,
  output logic                     result_valid_o,
  output logic [sstc_pkg::MW-1:0]  mean_alloc_q16_o,
  output logic signed [sstc_pkg::RW-1:0] correlation_q15_o,
  output logic [sstc_pkg::EW-1:0]  efficiency_q16_o,
  output logic [sstc_pkg::UKW-1:0] peak_kb_o
);
  import sstc_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_DIVM = 4'd1;
  localparam logic [3:0] S_DIVE = 4'd2;
  localparam logic [3:0] S_READ = 4'd3;
  localparam logic [3:0] S_SCAL = 4'd4;
  localparam logic [3:0] S_DEVN = 4'd5;
  localparam logic [3:0] S_MXY  = 4'd6;
  localparam logic [3:0] S_MXX  = 4'd7;
  localparam logic [3:0] S_MYY  = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_MAG  = 4'd10;
  localparam logic [3:0] S_RHS  = 4'd11;
  localparam logic [3:0] S_SEL  = 4'd12;
  localparam logic [3:0] S_TST  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam logic [RW-1:0] QMAX = 16'd32768;
  localparam logic [RW-1:0] QSAT = 16'd32767;

  logic [3:0]      state_q;
  logic            started_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   idx_q;
  logic [ATW-1:0]  at_q;
  logic [TTW-1:0]  tt_q;
  logic [UKW-1:0]  peak_q;
  logic [MW-1:0]   mean_q;
  logic [EW-1:0]   eff_q;
  logic [RW-1:0]   corr_q;
  logic [NXW-1:0]  nt_q;
  logic [NAW-1:0]  na_q;
  logic [NXW-1:0]  dt_q;
  logic [NAW-1:0]  da_q;
  logic            dneg_q;
  logic [POSW-1:0] pos_q;
  logic [POSW-1:0] neg_q;
  logic [STTW-1:0] stt_q;
  logic [SAAW-1:0] saa_q;
  logic [POSW-1:0] mag_q;
  logic            rneg_q;
  logic [PW-1:0]   lhs_q;
  logic [RHW-1:0]  rhs_q;
  logic [3:0]      bit_q;
  logic [RW-1:0]   qv_q;
  logic [31:0]     cc_q;

  logic [TW+AKW-1:0] mem_q [MAX_SAMPLES];
  logic [TW+AKW-1:0] rd_q;

  logic            accept;
  logic            wr_en;
  logic            rd_en;
  logic            mul_state;
  logic            div_state;
  logic            mul_go;
  logic            div_go;
  logic            mul_done;
  logic            div_done;
  logic [PW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   prod;
  logic [DNW-1:0]  div_n;
  logic [DVW-1:0]  div_d;
  logic [DNW-1:0]  quot;
  logic [RW-1:0]   cand;
  logic            pass_last;

  assign accept    = start_i && (state_q == S_LOAD);
  assign wr_en     = accept && (count_q < CW'(MAX_SAMPLES));
  assign rd_en     = (state_q == S_READ);
  assign cand      = qv_q | (RW'(1) << bit_q);
  assign pass_last = (idx_q + 1'b1) == count_q;

  // Sample memory: written while loading, read back during the second pass.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IW-1:0]] <= {elapsed_ns_i, alloc_kb_i};
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[IW-1:0]];
    end
  end

  // Operand selection for the shared serial units.
  always_comb begin
    mul_state = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_MXY: begin
        mul_state = 1'b1;
        mul_a     = PW'(dt_q);
        mul_b     = BW'(da_q);
      end
      S_MXX: begin
        mul_state = 1'b1;
        mul_a     = PW'(dt_q);
        mul_b     = BW'(dt_q);
      end
      S_MYY: begin
        mul_state = 1'b1;
        mul_a     = PW'(da_q);
        mul_b     = BW'(da_q);
      end
      S_MAG: begin
        mul_state = 1'b1;
        mul_a     = PW'(mag_q);
        mul_b     = BW'(mag_q);
      end
      S_RHS: begin
        mul_state = 1'b1;
        mul_a     = PW'(stt_q);
        mul_b     = BW'(saa_q);
      end
      S_TST: begin
        mul_state = 1'b1;
        mul_a     = PW'(rhs_q);
        mul_b     = BW'(cc_q);
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_state = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (state_q)
      S_DIVM: begin
        div_state = 1'b1;
        div_n     = {at_q, 16'd0};
        div_d     = DVW'(count_q);
      end
      S_DIVE: begin
        div_state = (at_q != '0);
        div_n     = DNW'({count_q, 16'd0});
        div_d     = at_q;
      end
      default: begin
        div_state = 1'b0;
      end
    endcase
  end

  assign mul_go = mul_state && !started_q;
  assign div_go = div_state && !started_q;

  sstc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  sstc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Sequencer for loading, the close divisions, the second pass and the search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      started_q <= 1'b0;
      count_q   <= '0;
      idx_q     <= '0;
      at_q      <= '0;
      tt_q      <= '0;
      peak_q    <= '0;
      mean_q    <= '0;
      eff_q     <= '0;
      corr_q    <= '0;
      nt_q      <= '0;
      na_q      <= '0;
      dt_q      <= '0;
      da_q      <= '0;
      dneg_q    <= 1'b0;
      pos_q     <= '0;
      neg_q     <= '0;
      stt_q     <= '0;
      saa_q     <= '0;
      mag_q     <= '0;
      rneg_q    <= 1'b0;
      lhs_q     <= '0;
      rhs_q     <= '0;
      bit_q     <= '0;
      qv_q      <= '0;
      cc_q      <= '0;
    end else begin
      if (mul_go || div_go) begin
        started_q <= 1'b1;
      end
      if (mul_done || div_done) begin
        started_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (wr_en) begin
            count_q <= count_q + 1'b1;
            tt_q    <= tt_q + TTW'(elapsed_ns_i);
            at_q    <= at_q + ATW'(alloc_kb_i);
            if (in_use_after_kb_i > peak_q) begin
              peak_q <= in_use_after_kb_i;
            end
          end
          if (accept && final_sample_i) begin
            pos_q   <= '0;
            neg_q   <= '0;
            stt_q   <= '0;
            saa_q   <= '0;
            idx_q   <= '0;
            state_q <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_done) begin
            mean_q  <= quot[MW-1:0];
            state_q <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (at_q == '0) begin
            eff_q   <= '0;
            state_q <= S_READ;
          end else if (div_done) begin
            eff_q   <= (quot > DNW'(32'hFFFF_FFFF)) ? '1 : quot[EW-1:0];
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_SCAL;
        end
        // Scale the sample by the count so deviations stay exact integers.
        S_SCAL: begin
          nt_q    <= NXW'(count_q) * NXW'(rd_q[TW+AKW-1:AKW]);
          na_q    <= NAW'(count_q) * NAW'(rd_q[AKW-1:0]);
          state_q <= S_DEVN;
        end
        S_DEVN: begin
          dt_q    <= (nt_q >= NXW'(tt_q)) ? (nt_q - NXW'(tt_q)) : (NXW'(tt_q) - nt_q);
          da_q    <= (na_q >= NAW'(at_q)) ? (na_q - NAW'(at_q)) : (NAW'(at_q) - na_q);
          dneg_q  <= (nt_q < NXW'(tt_q)) != (na_q < NAW'(at_q));
          state_q <= S_MXY;
        end
        S_MXY: begin
          if (mul_done) begin
            if (dneg_q) begin
              neg_q <= neg_q + prod[POSW-1:0];
            end else begin
              pos_q <= pos_q + prod[POSW-1:0];
            end
            state_q <= S_MXX;
          end
        end
        S_MXX: begin
          if (mul_done) begin
            stt_q   <= stt_q + prod[STTW-1:0];
            state_q <= S_MYY;
          end
        end
        S_MYY: begin
          if (mul_done) begin
            saa_q <= saa_q + prod[SAAW-1:0];
            idx_q <= idx_q + 1'b1;
            state_q <= pass_last ? S_CHK : S_READ;
          end
        end
        // A flat series gives a zero coefficient.
        S_CHK: begin
          if ((stt_q == '0) || (saa_q == '0)) begin
            corr_q  <= '0;
            state_q <= S_OUT;
          end else begin
            rneg_q  <= pos_q < neg_q;
            mag_q   <= (pos_q >= neg_q) ? (pos_q - neg_q) : (neg_q - pos_q);
            state_q <= S_MAG;
          end
        end
        S_MAG: begin
          if (mul_done) begin
            lhs_q   <= prod << 30;
            state_q <= S_RHS;
          end
        end
        S_RHS: begin
          if (mul_done) begin
            rhs_q   <= prod[RHW-1:0];
            bit_q   <= 4'd15;
            qv_q    <= '0;
            state_q <= S_SEL;
          end
        end
        // Bitwise search for the largest q with rhs*q*q not above lhs.
        S_SEL: begin
          if (cand > QMAX) begin
            if (bit_q == '0) begin
              state_q <= S_FIN;
            end else begin
              bit_q <= bit_q - 1'b1;
            end
          end else begin
            cc_q    <= 32'(cand) * 32'(cand);
            state_q <= S_TST;
          end
        end
        S_TST: begin
          if (mul_done) begin
            if (prod <= lhs_q) begin
              qv_q <= cand;
            end
            if (bit_q == '0) begin
              state_q <= S_FIN;
            end else begin
              bit_q   <= bit_q - 1'b1;
              state_q <= S_SEL;
            end
          end
        end
        S_FIN: begin
          corr_q  <= rneg_q ? (RW'(0) - qv_q) : ((qv_q > QSAT) ? QSAT : qv_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          count_q <= '0;
          at_q    <= '0;
          tt_q    <= '0;
          peak_q  <= '0;
          state_q <= S_LOAD;
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign busy_o            = (state_q != S_LOAD);
  assign result_valid_o    = (state_q == S_OUT);
  assign mean_alloc_q16_o  = mean_q;
  assign correlation_q15_o = $signed(corr_q);
  assign efficiency_q16_o  = eff_q;
  assign peak_kb_o         = peak_q;

  // The result beat lasts exactly one cycle.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // A closing sample always starts the close sequence.
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && final_sample_i) |=> busy_o)
    else $error("closing sample did not raise busy");

  // The stored count never passes the memory depth.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("stored count past memory depth");

  // Nothing is accepted while the result is shown.
  a_no_take_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result shown while accepting samples");

endmodule
